>>> src/lcg_random_in_range_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LCG random-in-range core
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LCG_RANDOM_IN_RANGE_CORE_ASSERT_SVH
`define LCG_RANDOM_IN_RANGE_CORE_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every edge outside reset
`define LCGR_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define LCGR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define LCGR_ASSERT(lbl, ck, rn, prop, msg)
`define LCGR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

>>> src/lcgr_pkg.sv
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared widths, generator constants and types of the LCG random-in-range core.
// ----------------------------------------------------------------------------
package lcgr_pkg;

	localparam int STATE_W = 31;
	localparam int BOUND_W = 16;
	localparam int DIV_W   = BOUND_W + 1;
	localparam int CNT_W   = 5;

	// ANSI C generator: state = (mult * state + incr) mod 2^31
	localparam logic [STATE_W-1:0] LCG_MULT = 31'd1103515245;
	localparam logic [STATE_W-1:0] LCG_INCR = 31'd12345;

	// Job handed from front to back: advanced state and inclusive bound
	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [BOUND_W-1:0] bound;
	} job_t;

	// Back-end sequencer
	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_DIV  = 3'b010,
		BK_HOLD = 3'b100
	} bk_state_t;

	// Back-end status seen by the top level
	typedef struct packed {
		logic busy;
		logic out_valid;
	} bk_stat_t;

endpackage

>>> src/lcg_random_in_range_core.sv
// ----------------------------------------------------------------------------
// lcg_random_in_range_core
// Random number generator returning a value in 0..max_value per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive max_value and push; a word is taken when full is low.
//   The front steps the 31-bit ANSI C generator in the accept cycle and
//   queues the new state with the bound.
//   Result side: random_value is valid while empty is low; pop takes it.
//   The back end reduces the state modulo (max_value + 1) one dividend bit
//   per cycle, 31 steps, then loads the result register once the slot is free.
//   Sustained throughput is set by the serial remainder loop; up to
//   QUEUE_DEPTH requests queue while it runs.
//   A stalled result side holds the finished word; the back end then waits
//   with its next remainder, and full rises once the queue fills.
//   Seed port: a cfg_valid word loads the generator state; cfg_ready is
//   always high. Write it only while no request is outstanding.
//   Reset clears the generator state to zero and empties the queue.
// ----------------------------------------------------------------------------
`include "lcg_random_in_range_core_assert.svh"

module lcg_random_in_range_core
	import lcgr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [BOUND_W-1:0] max_value,
	output logic               empty,
	input  logic               pop,
	output logic [BOUND_W-1:0] random_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [STATE_W-1:0] seed
);

	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	job_t     q_wdata;
	job_t     q_rdata;
	bk_stat_t bk_stat;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// generator front
	lcgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.max_value (max_value),
		.cfg_valid (cfg_valid),
		.seed      (seed),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// job queue
	lcgr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	// remainder back end
	lcgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.random_value (random_value),
		.stat         (bk_stat)
	);

	// checks
	`LCGR_ASSERT(a_q_not_full_and_empty, clk, arst_n, !(q_full && q_empty), "queue full and empty")
	`LCGR_ASSERT_NEXT(a_push_fills_q, clk, arst_n, q_push, !q_empty, "pushed word lost")
	`LCGR_ASSERT(a_pop_only_idle, clk, arst_n, !(q_pop && (bk_stat.busy || q_empty)), "bad pop")
	`LCGR_ASSERT(a_out_matches_empty, clk, arst_n, bk_stat.out_valid == !empty, "result flag")

endmodule

>>> src/lcgr_fifo.sv
// ----------------------------------------------------------------------------
// lcgr_fifo
// Short job queue between the generator front and the remainder back end.
// ----------------------------------------------------------------------------
module lcgr_fifo
	import lcgr_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage, written only on an accepted word
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({wr_en && !full, rd_en && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/lcgr_front.sv
// ----------------------------------------------------------------------------
// lcgr_front
// Holds the generator state, advances it per request and emits a job word.
// ----------------------------------------------------------------------------
module lcgr_front
	import lcgr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [BOUND_W-1:0] max_value,
	input  logic               cfg_valid,
	input  logic [STATE_W-1:0] seed,
	input  logic               q_full,
	output logic               q_push,
	output job_t               q_data
);

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] prod_lo;
	logic [STATE_W-1:0] state_nxt;

	// only the low 31 bits of the product survive the modulo
	assign prod_lo   = STATE_W'(state_q * LCG_MULT);
	assign state_nxt = prod_lo + LCG_INCR;

	assign q_push       = push && !q_full;
	assign q_data.state = state_nxt;
	assign q_data.bound = max_value;

	// generator state: reseeded by a config write, stepped per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cfg_valid) begin
			state_q <= seed;
		end else if (q_push) begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> src/lcgr_back.sv
// ----------------------------------------------------------------------------
// lcgr_back
// Bit-serial remainder of the state by (bound + 1) and the result register.
// ----------------------------------------------------------------------------
module lcgr_back
	import lcgr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  job_t               q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [BOUND_W-1:0] random_value,
	output bk_stat_t           stat
);

	bk_state_t          st_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STATE_W-1:0] dvd_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   rem_q;
	logic               out_valid_q;
	logic [BOUND_W-1:0] out_q;

	logic [DIV_W:0]     rem_sh;
	logic [DIV_W:0]     rem_diff;
	logic [DIV_W-1:0]   rem_nxt;
	logic               slot_free;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh   = {rem_q, dvd_q[STATE_W-1]};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign rem_nxt  = rem_diff[DIV_W] ? rem_sh[DIV_W-1:0] : rem_diff[DIV_W-1:0];

	assign slot_free    = !out_valid_q || pop;
	assign q_pop        = (st_q == BK_IDLE) && !q_empty;
	assign empty        = !out_valid_q;
	assign random_value = out_q;
	assign stat.busy      = (st_q != BK_IDLE);
	assign stat.out_valid = out_valid_q;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				BK_IDLE: begin
					if (!q_empty) begin
						cnt_q <= '0;
						st_q  <= BK_DIV;
					end
				end
				BK_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STATE_W - 1)) begin
						st_q <= BK_HOLD;
					end
				end
				BK_HOLD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						st_q        <= BK_IDLE;
					end
				end
				default: st_q <= BK_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				dvd_q <= q_data.state;
				div_q <= {1'b0, q_data.bound} + 1'b1;
				rem_q <= '0;
			end
			BK_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[STATE_W-2:0], 1'b0};
			end
			BK_HOLD: begin
				if (slot_free) begin
					out_q <= rem_q[BOUND_W-1:0];
				end
			end
			default: rem_q <= rem_q;
		endcase
	end

endmodule
